@@ hw/rtl/cfsuv_pkg.sv @@
// ----------------------------------------------------------------------------
// cfsuv_pkg: shared types and constants for cube face selection
// Field widths, face codes and the control bundle that rides the cell chain.
// ----------------------------------------------------------------------------
package cfsuv_pkg;

  localparam int DIR_W       = 16;  // Q1.14 direction component
  localparam int MAG_W       = 16;  // magnitude, up to 32768
  localparam int NUM_W       = 17;  // sc + m, up to 65536
  localparam int FACE_W      = 3;
  localparam int UV_BITS_DEF = 16;

  typedef enum logic [FACE_W-1:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_e;

  typedef struct packed {
    face_e face;
    logic  zero_dir;
  } ctl_t;

endpackage

@@ hw/rtl/cfsuv_front.sv @@
// ----------------------------------------------------------------------------
// cfsuv_front: major axis select and integer quotient step
// Stage one picks the face, the major magnitude and the signed face
// coordinates; stage two forms sc + m and takes the integer part of the
// first division, seeding the remainder for the fractional cells.
// ----------------------------------------------------------------------------
module cfsuv_front #(
  parameter int UV_BITS = cfsuv_pkg::UV_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [cfsuv_pkg::DIR_W-1:0]    dir_x_i,
  input  logic signed [cfsuv_pkg::DIR_W-1:0]    dir_y_i,
  input  logic signed [cfsuv_pkg::DIR_W-1:0]    dir_z_i,
  output logic                                  valid_o,
  output cfsuv_pkg::ctl_t                       ctl_o,
  output logic        [cfsuv_pkg::MAG_W-1:0]    mag_o,
  output logic        [cfsuv_pkg::MAG_W-1:0]    rem_u_o,
  output logic        [cfsuv_pkg::MAG_W-1:0]    rem_v_o,
  output logic        [UV_BITS+1:0]             quo_u_o,
  output logic        [UV_BITS+1:0]             quo_v_o
);
  import cfsuv_pkg::*;

  localparam int QW = UV_BITS + 2;

  // stage one
  logic                    s1_valid_q;
  ctl_t                    s1_ctl_q, s1_ctl_d;
  logic        [MAG_W-1:0] s1_mag_q, s1_mag_d;
  logic signed [NUM_W-1:0] s1_sc_q, s1_sc_d, s1_tc_q, s1_tc_d;

  logic        [MAG_W-1:0] ax, ay, az;
  logic signed [NUM_W-1:0] xs, ys, zs;

  always_comb begin
    xs = NUM_W'(dir_x_i);
    ys = NUM_W'(dir_y_i);
    zs = NUM_W'(dir_z_i);
    ax = dir_x_i[DIR_W-1] ? MAG_W'(-dir_x_i) : MAG_W'(dir_x_i);
    ay = dir_y_i[DIR_W-1] ? MAG_W'(-dir_y_i) : MAG_W'(dir_y_i);
    az = dir_z_i[DIR_W-1] ? MAG_W'(-dir_z_i) : MAG_W'(dir_z_i);
    s1_ctl_d.zero_dir = (ax == '0) && (ay == '0) && (az == '0);
    priority if (ax >= ay && ax >= az) begin
      s1_mag_d = ax;
      s1_tc_d  = -ys;
      if (dir_x_i > 0) begin
        s1_ctl_d.face = FACE_PX;
        s1_sc_d       = -zs;
      end else begin
        s1_ctl_d.face = FACE_NX;
        s1_sc_d       = zs;
      end
    end else if (ay >= az) begin
      s1_mag_d = ay;
      s1_sc_d  = xs;
      if (dir_y_i > 0) begin
        s1_ctl_d.face = FACE_PY;
        s1_tc_d       = zs;
      end else begin
        s1_ctl_d.face = FACE_NY;
        s1_tc_d       = -zs;
      end
    end else begin
      s1_mag_d = az;
      s1_tc_d  = -ys;
      if (dir_z_i > 0) begin
        s1_ctl_d.face = FACE_PZ;
        s1_sc_d       = xs;
      end else begin
        s1_ctl_d.face = FACE_NZ;
        s1_sc_d       = -xs;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_ctl_q <= s1_ctl_d;
      s1_mag_q <= s1_mag_d;
      s1_sc_q  <= s1_sc_d;
      s1_tc_q  <= s1_tc_d;
    end
  end

  // stage two: integer part of (sc + m) / m is 0, 1 or 2
  logic             s2_valid_q;
  ctl_t             s2_ctl_q;
  logic [MAG_W-1:0] s2_mag_q, s2_rem_u_q, s2_rem_v_q, s2_rem_u_d, s2_rem_v_d;
  logic [QW-1:0]    s2_quo_u_q, s2_quo_v_q, s2_quo_u_d, s2_quo_v_d;
  logic [NUM_W-1:0] num_u, num_v, mag1, mag2;

  always_comb begin
    mag1  = NUM_W'(s1_mag_q);
    mag2  = {s1_mag_q, 1'b0};
    num_u = NUM_W'(s1_sc_q + $signed(mag1));
    num_v = NUM_W'(s1_tc_q + $signed(mag1));
    priority if (num_u >= mag2) begin
      s2_rem_u_d = MAG_W'(num_u - mag2);
      s2_quo_u_d = QW'(2);
    end else if (num_u >= mag1) begin
      s2_rem_u_d = MAG_W'(num_u - mag1);
      s2_quo_u_d = QW'(1);
    end else begin
      s2_rem_u_d = MAG_W'(num_u);
      s2_quo_u_d = '0;
    end
    priority if (num_v >= mag2) begin
      s2_rem_v_d = MAG_W'(num_v - mag2);
      s2_quo_v_d = QW'(2);
    end else if (num_v >= mag1) begin
      s2_rem_v_d = MAG_W'(num_v - mag1);
      s2_quo_v_d = QW'(1);
    end else begin
      s2_rem_v_d = MAG_W'(num_v);
      s2_quo_v_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_ctl_q   <= s1_ctl_q;
      s2_mag_q   <= s1_mag_q;
      s2_rem_u_q <= s2_rem_u_d;
      s2_rem_v_q <= s2_rem_v_d;
      s2_quo_u_q <= s2_quo_u_d;
      s2_quo_v_q <= s2_quo_v_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign ctl_o   = s2_ctl_q;
  assign mag_o   = s2_mag_q;
  assign rem_u_o = s2_rem_u_q;
  assign rem_v_o = s2_rem_v_q;
  assign quo_u_o = s2_quo_u_q;
  assign quo_v_o = s2_quo_v_q;

endmodule

@@ hw/rtl/cfsuv_div_cell.sv @@
// ----------------------------------------------------------------------------
// cfsuv_div_cell: one restoring division step for the u and v lanes
// Shifts each remainder left, subtracts the major magnitude where it fits
// and appends one quotient bit, then hands the transaction to the next cell.
// ----------------------------------------------------------------------------
module cfsuv_div_cell #(
  parameter int UV_BITS = cfsuv_pkg::UV_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  cfsuv_pkg::ctl_t                ctl_i,
  input  logic [cfsuv_pkg::MAG_W-1:0]    mag_i,
  input  logic [cfsuv_pkg::MAG_W-1:0]    rem_u_i,
  input  logic [cfsuv_pkg::MAG_W-1:0]    rem_v_i,
  input  logic [UV_BITS+1:0]             quo_u_i,
  input  logic [UV_BITS+1:0]             quo_v_i,
  output logic                           valid_o,
  output cfsuv_pkg::ctl_t                ctl_o,
  output logic [cfsuv_pkg::MAG_W-1:0]    mag_o,
  output logic [cfsuv_pkg::MAG_W-1:0]    rem_u_o,
  output logic [cfsuv_pkg::MAG_W-1:0]    rem_v_o,
  output logic [UV_BITS+1:0]             quo_u_o,
  output logic [UV_BITS+1:0]             quo_v_o
);
  import cfsuv_pkg::*;

  localparam int QW = UV_BITS + 2;

  logic             valid_q;
  ctl_t             ctl_q;
  logic [MAG_W-1:0] mag_q, rem_u_q, rem_v_q, rem_u_d, rem_v_d;
  logic [QW-1:0]    quo_u_q, quo_v_q, quo_u_d, quo_v_d;
  logic [MAG_W:0]   sh_u, sh_v, div;
  logic             ge_u, ge_v;

  always_comb begin
    div     = {1'b0, mag_i};
    sh_u    = {rem_u_i, 1'b0};
    sh_v    = {rem_v_i, 1'b0};
    ge_u    = sh_u >= div;
    ge_v    = sh_v >= div;
    // remainder stays below the magnitude, so it fits again after the subtract
    rem_u_d = ge_u ? MAG_W'(sh_u - div) : MAG_W'(sh_u);
    rem_v_d = ge_v ? MAG_W'(sh_v - div) : MAG_W'(sh_v);
    quo_u_d = {quo_u_i[QW-2:0], ge_u};
    quo_v_d = {quo_v_i[QW-2:0], ge_v};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q   <= ctl_i;
      mag_q   <= mag_i;
      rem_u_q <= rem_u_d;
      rem_v_q <= rem_v_d;
      quo_u_q <= quo_u_d;
      quo_v_q <= quo_v_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign mag_o   = mag_q;
  assign rem_u_o = rem_u_q;
  assign rem_v_o = rem_v_q;
  assign quo_u_o = quo_u_q;
  assign quo_v_o = quo_v_q;

endmodule

@@ hw/rtl/cube_face_select_uv_top.sv @@
// ----------------------------------------------------------------------------
// cube_face_select_uv_top: cube map face and face coordinate unit
// Takes one direction vector per transaction and returns the face and the
// rounded, saturated u/v face coordinates.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock while the output side keeps up; a
// result passes through a selection stage, an integer quotient stage, the
// chain of UV_BITS division cells, each producing one quotient bit of u and
// of v, and the output register.
// A stalled output holds the whole chain in place.
// An all-zero vector returns face -X with u = v = one half and zero_dir set.
module cube_face_select_uv_top #(
  parameter int UV_BITS = cfsuv_pkg::UV_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // dir_x [15:0], dir_y [31:16], dir_z [47:32]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // face [2:0], tex_u [UV_BITS+2:3], tex_v [2*UV_BITS+2:UV_BITS+3], zero pad
  output logic [((cfsuv_pkg::FACE_W + 2*UV_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // zero_dir [0]
  output logic        m_axis_tuser
);
  import cfsuv_pkg::*;

  localparam int QW   = UV_BITS + 2;
  localparam int TD_W = ((FACE_W + 2*UV_BITS + 7) / 8) * 8;

  logic en;

  // index 0 is the front output, index UV_BITS the last cell
  logic             ch_valid [UV_BITS+1];
  ctl_t             ch_ctl   [UV_BITS+1];
  logic [MAG_W-1:0] ch_mag   [UV_BITS+1];
  logic [MAG_W-1:0] ch_rem_u [UV_BITS+1];
  logic [MAG_W-1:0] ch_rem_v [UV_BITS+1];
  logic [QW-1:0]    ch_quo_u [UV_BITS+1];
  logic [QW-1:0]    ch_quo_v [UV_BITS+1];

  logic               out_valid_q;
  face_e              face_q;
  logic [UV_BITS-1:0] tex_u_q, tex_v_q, tex_u_d, tex_v_d;
  logic               zero_q;

  // advance everything whenever the output slot frees up
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  cfsuv_front #(
    .UV_BITS (UV_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .dir_x_i (s_axis_tdata[15:0]),
    .dir_y_i (s_axis_tdata[31:16]),
    .dir_z_i (s_axis_tdata[47:32]),
    .valid_o (ch_valid[0]),
    .ctl_o   (ch_ctl[0]),
    .mag_o   (ch_mag[0]),
    .rem_u_o (ch_rem_u[0]),
    .rem_v_o (ch_rem_v[0]),
    .quo_u_o (ch_quo_u[0]),
    .quo_v_o (ch_quo_v[0])
  );

  for (genvar i = 0; i < UV_BITS; i++) begin : g_cell
    cfsuv_div_cell #(
      .UV_BITS (UV_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (ch_valid[i]),
      .ctl_i   (ch_ctl[i]),
      .mag_i   (ch_mag[i]),
      .rem_u_i (ch_rem_u[i]),
      .rem_v_i (ch_rem_v[i]),
      .quo_u_i (ch_quo_u[i]),
      .quo_v_i (ch_quo_v[i]),
      .valid_o (ch_valid[i+1]),
      .ctl_o   (ch_ctl[i+1]),
      .mag_o   (ch_mag[i+1]),
      .rem_u_o (ch_rem_u[i+1]),
      .rem_v_o (ch_rem_v[i+1]),
      .quo_u_o (ch_quo_u[i+1]),
      .quo_v_o (ch_quo_v[i+1])
    );
  end

  // quotient k = floor((sc+m) * 2^UV_BITS / m); coordinate is (k + 1) / 2
  logic [QW-1:0]    kp1_u, kp1_v;
  logic [UV_BITS:0] val_u, val_v;

  always_comb begin
    kp1_u = ch_quo_u[UV_BITS] + QW'(1);
    kp1_v = ch_quo_v[UV_BITS] + QW'(1);
    val_u = kp1_u[QW-1:1];
    val_v = kp1_v[QW-1:1];
    if (ch_ctl[UV_BITS].zero_dir) begin
      tex_u_d = {1'b1, {(UV_BITS-1){1'b0}}};
      tex_v_d = {1'b1, {(UV_BITS-1){1'b0}}};
    end else begin
      tex_u_d = val_u[UV_BITS] ? '1 : val_u[UV_BITS-1:0];
      tex_v_d = val_v[UV_BITS] ? '1 : val_v[UV_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ch_valid[UV_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      face_q  <= ch_ctl[UV_BITS].face;
      zero_q  <= ch_ctl[UV_BITS].zero_dir;
      tex_u_q <= tex_u_d;
      tex_v_q <= tex_v_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TD_W'({tex_v_q, tex_u_q, face_q});
  assign m_axis_tuser  = zero_q;

  // a zero vector always reports face -X at the center of the face
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && zero_q) |->
      (face_q == FACE_NX && tex_u_q == {1'b1, {(UV_BITS-1){1'b0}}} &&
       tex_v_q == {1'b1, {(UV_BITS-1){1'b0}}}))
    else $error("zero vector result is not face -X at one half");

  // a stalled result blocks new input transactions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // a result held under stall leaves the last cell untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=>
      ($stable(ch_valid[UV_BITS]) && $stable(ch_quo_u[UV_BITS]) &&
       $stable(ch_quo_v[UV_BITS])))
    else $error("cell chain advanced during output stall");

  // an accepted transaction reaches the first front stage on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> u_front.s1_valid_q)
    else $error("accepted transaction lost at front stage");

endmodule
